FILE: rtl/core/hsws_pkg.sv
// ----------------------------------------------------------------------------
// hsws_pkg
// shared constants, codes and types of the hardware stack with swap
// ----------------------------------------------------------------------------
package hsws_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_READ = 2'd2,
        ACT_SWAP = 2'd3
    } action_t;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0]      count_t;
    typedef logic [ADDR_W-1:0]     addr_t;

    // one finished response as it leaves on the output channel
    typedef struct packed {
        logic signed [31:0] top_value;
        logic               top_valid;
        logic [10:0]        entry_count;
        logic               is_empty;
        logic               is_full;
        logic               status;
    } result_t;

endpackage

FILE: rtl/core/hsws_ram.sv
// ----------------------------------------------------------------------------
// hsws_ram
// single-port synchronous ram, read-first, registered read data
// ----------------------------------------------------------------------------
module hsws_ram #(
    parameter int WORDS = 1024,
    parameter int WIDTH = 32
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [WORDS];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/hsws_ctrl.sv
// ----------------------------------------------------------------------------
// hsws_ctrl
// stack sequencer: count, cached top entry and memory access control
// ----------------------------------------------------------------------------
module hsws_ctrl
    import hsws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [31:0] push_value,
    input  logic               out_free,
    output logic               done,
    output result_t            result,
    output logic               mem_we,
    output addr_t              mem_addr,
    output word_t              mem_wdata,
    input  word_t              mem_rdata
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_SWAP = 3'b100
    } state_t;

    state_t state_reg, state_next;
    count_t count_reg, count_next;
    word_t  top_reg, top_next;
    logic   ignored;
    logic   accept;
    logic   is_full_now;
    logic   is_empty_now;
    addr_t  addr_m1;
    addr_t  addr_m2;
    logic signed [63:0] push_ext;
    logic signed [63:0] top_ext;
    logic [31:0]        cnt_wide;

    assign in_ready     = (state_reg == S_IDLE) && out_free;
    assign accept       = in_valid && in_ready;
    assign is_full_now  = (count_reg == CNT_W'(DEPTH));
    assign is_empty_now = (count_reg == '0);
    assign addr_m1      = ADDR_W'(count_reg - CNT_W'(1));
    assign addr_m2      = ADDR_W'(count_reg - CNT_W'(2));
    assign push_ext     = 64'(push_value);

    // the top entry lives in top_reg; the ram holds the entries beneath it
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        top_next   = top_reg;
        mem_we     = 1'b0;
        mem_addr   = addr_m2;
        mem_wdata  = top_reg;
        done       = 1'b0;
        ignored    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action_t'(action))
                        ACT_PUSH:
                        begin
                            done = 1'b1;
                            if (is_full_now)
                            begin
                                ignored = 1'b1;
                            end
                            else
                            begin
                                mem_we     = !is_empty_now;
                                mem_addr   = addr_m1;
                                top_next   = push_ext[DATA_WIDTH-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_POP:
                        begin
                            if (is_empty_now)
                            begin
                                ignored = 1'b1;
                                done    = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                if (count_reg == CNT_W'(1))
                                begin
                                    done = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_LOAD;
                                end
                            end
                        end
                        ACT_READ:
                        begin
                            ignored = is_empty_now;
                            done    = 1'b1;
                        end
                        ACT_SWAP:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                ignored = 1'b1;
                                done    = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SWAP;
                            end
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                // new top arrives from the entry just below the old one
                top_next   = mem_rdata;
                done       = 1'b1;
                state_next = S_IDLE;
            end
            S_SWAP:
            begin
                // old top goes down, second entry comes up
                top_next   = mem_rdata;
                mem_we     = 1'b1;
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign top_ext  = 64'(signed'(top_next));
    assign cnt_wide = 32'(count_next);

    always_comb
    begin
        result.top_value   = (count_next == '0) ? 32'sd0 : top_ext[31:0];
        result.top_valid   = (count_next != '0);
        result.entry_count = cnt_wide[10:0];
        result.is_empty    = (count_next == '0);
        result.is_full     = (count_next == CNT_W'(DEPTH));
        result.status      = ignored;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("stack count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("stack count moved by more than one");

    a_swap_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == ACT_SWAP && count_reg >= CNT_W'(2)) |=>
            (state_reg == S_SWAP && count_reg == $past(count_reg)))
        else $error("swap did not enter its write-back cycle");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (done && out_free))
        else $error("memory wait state without a free output register");

endmodule

FILE: rtl/core/hardware_stack_with_swap_top.sv
// ----------------------------------------------------------------------------
// hardware_stack_with_swap_top
// last-in first-out stack of signed words with push, pop, read and swap
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries one request: action and
//   push_value. output channel out_valid/out_ready returns one response per
//   request: top entry after the action, its valid flag, entry count, empty
//   and full flags, and status (1 when the action was refused)
//   push, read and any refused request answer in the cycle after
//   acceptance; pop of a stack with two or more entries and swap also
//   pass through S_LOAD or S_SWAP, set by the single ram port (one read,
//   then for a swap one write-back of the old top)
//   a new request waits until the previous one is done and is taken in
//   the cycle its predecessor's response is handed over
//   the top entry is held in a register, the ram keeps the entries beneath
//   reset clears the count and control; ram contents stay undefined, no
//   clearing pass is needed since only pushed entries are ever read
//   a stalled receiver holds the response in the output register and
//   in_ready stays low until it is taken
// ----------------------------------------------------------------------------
module hardware_stack_with_swap_top
    import hsws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] top_value,
    output logic               top_valid,
    output logic [10:0]        entry_count,
    output logic               is_empty,
    output logic               is_full,
    output logic               status
);

    logic    out_valid_reg;
    result_t result_reg;
    result_t result;
    logic    out_free;
    logic    done;
    logic    mem_we;
    addr_t   mem_addr;
    word_t   mem_wdata;
    word_t   mem_rdata;

    // output register frees up in the same cycle its response is taken
    assign out_free = !out_valid_reg || out_ready;

    hsws_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .push_value (push_value),
        .out_free   (out_free),
        .done       (done),
        .result     (result),
        .mem_we     (mem_we),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata)
    );

    // entries beneath the top, one port shared by reads and write-backs
    hsws_ram #(
        .WORDS (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // response payload, loaded only when a request completes
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            result_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign top_value   = result_reg.top_value;
    assign top_valid   = result_reg.top_valid;
    assign entry_count = result_reg.entry_count;
    assign is_empty    = result_reg.is_empty;
    assign is_full     = result_reg.is_full;
    assign status      = result_reg.status;

endmodule

FILE: bench/hsws_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsws_checker
// watches both channels of the stack, predicts every response and compares
// ----------------------------------------------------------------------------
module hsws_checker
    import hsws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [31:0] push_value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] top_value,
    input  logic               top_valid,
    input  logic [10:0]        entry_count,
    input  logic               is_empty,
    input  logic               is_full,
    input  logic               status,
    output int                 fail_count,
    output int                 pending,
    output int                 checked,
    output int                 refused,
    output int                 peak_depth
);

    // shadow copy of the stack contents and fill level
    word_t   shadow_words [DEPTH];
    int      shadow_count;
    result_t due_responses [$];
    int      shown;

    initial
    begin
        shadow_count = 0;
        shown        = 0;
        fail_count   = 0;
        pending      = 0;
        checked      = 0;
        refused      = 0;
        peak_depth   = 0;
    end

    // apply one request to the shadow stack and return the response it owes
    function automatic result_t apply_stack_action(action_t act, word_t value);
        result_t resp;
        word_t   held;
        logic    ignored;
        ignored = 1'b0;
        case (act)
            ACT_PUSH:
                if (shadow_count >= DEPTH)
                    ignored = 1'b1;
                else
                begin
                    shadow_words[shadow_count] = value;
                    shadow_count++;
                end
            ACT_POP:
                if (shadow_count == 0)
                    ignored = 1'b1;
                else
                    shadow_count--;
            ACT_READ:
                if (shadow_count == 0)
                    ignored = 1'b1;
            default:
                if (shadow_count < 2)
                    ignored = 1'b1;
                else
                begin
                    held                           = shadow_words[shadow_count - 1];
                    shadow_words[shadow_count - 1] = shadow_words[shadow_count - 2];
                    shadow_words[shadow_count - 2] = held;
                end
        endcase
        if (shadow_count > peak_depth)
            peak_depth = shadow_count;
        if (ignored)
            refused++;
        resp.top_value   = (shadow_count == 0) ? 32'sd0 : $signed(shadow_words[shadow_count - 1]);
        resp.top_valid   = (shadow_count != 0);
        resp.entry_count = 11'(shadow_count);
        resp.is_empty    = (shadow_count == 0);
        resp.is_full     = (shadow_count == DEPTH);
        resp.status      = ignored;
        return resp;
    endfunction

    function automatic int field_bad(string field, longint want_v, longint got_v);
        if (want_v == got_v)
            return 0;
        if (shown < 10)
            $display("mismatch at %0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
        shown++;
        return 1;
    endfunction

    always @(posedge clk)
    begin : watch
        result_t got;
        result_t want;
        int      bad;
        if (rst_n)
        begin
            // responses first: one leaving now never belongs to a request taken now
            if (out_valid && out_ready)
            begin
                got.top_value   = top_value;
                got.top_valid   = top_valid;
                got.entry_count = entry_count;
                got.is_empty    = is_empty;
                got.is_full     = is_full;
                got.status      = status;
                if (due_responses.size() == 0)
                begin
                    if (shown < 10)
                        $display("mismatch at %0t: response with no request waiting", $time);
                    shown++;
                    fail_count++;
                end
                else
                begin
                    want = due_responses.pop_front();
                    bad  = field_bad("top_value", want.top_value, got.top_value)
                         + field_bad("top_valid", want.top_valid, got.top_valid)
                         + field_bad("entry_count", want.entry_count, got.entry_count)
                         + field_bad("is_empty", want.is_empty, got.is_empty)
                         + field_bad("is_full", want.is_full, got.is_full)
                         + field_bad("status", want.status, got.status);
                    if (bad != 0)
                        fail_count++;
                    checked++;
                end
            end
            if (in_valid && in_ready)
                due_responses.push_back(apply_stack_action(action_t'(action),
                                                           word_t'(push_value)));
            pending = due_responses.size();
        end
    end

endmodule

FILE: bench/hardware_stack_with_swap_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hardware_stack_with_swap_top_test
// drives random and directed push, pop, read and swap requests into the
// stack, builds it up deep and drains it past empty again, and leaves the
// checking to hsws_checker
// ----------------------------------------------------------------------------
module hardware_stack_with_swap_top_test;
    import hsws_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 150;
    localparam int FILL_PUSHES = 120;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [1:0]         action     = ACT_READ;
    logic signed [31:0] push_value = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic signed [31:0] top_value;
    logic               top_valid;
    logic [10:0]        entry_count;
    logic               is_empty;
    logic               is_full;
    logic               status;

    int fail_count;
    int pending;
    int checked;
    int refused;
    int peak_depth;

    // stimulus bookkeeping
    int requests_sent = 0;
    int cycles        = 0;
    int stall_left    = 0;
    bit idle_on       = 1'b0;
    bit hold_off      = 1'b0;

    hardware_stack_with_swap_top DUT (
        .clk, .rst_n, .in_valid, .in_ready, .action, .push_value,
        .out_valid, .out_ready, .top_value, .top_valid, .entry_count,
        .is_empty, .is_full, .status
    );

    hsws_checker u_checker (
        .clk, .rst_n, .in_valid, .in_ready, .action, .push_value,
        .out_valid, .out_ready, .top_value, .top_valid, .entry_count,
        .is_empty, .is_full, .status,
        .fail_count, .pending, .checked, .refused, .peak_depth
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver pacing: random stall bursts while idling is on, plus the
    // long hold-off below
    always @(posedge clk)
    begin : rx_pace
        int next_stall;
        next_stall = (stall_left > 0) ? stall_left - 1 : 0;
        if (next_stall == 0 && idle_on && $urandom_range(0, 4) == 0)
            next_stall = $urandom_range(1, 4);
        stall_left <= next_stall;
        out_ready  <= (next_stall == 0) && !hold_off;
    end

    // long hold-off on the receiver: the response register fills, in_ready
    // drops and the sender keeps its request waiting
    initial
    begin
        while (requests_sent < 150)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("hardware_stack_with_swap_top test failed");
        $finish;
    end

    // offer one request and wait until it is taken; an optional random idle gap
    // goes in front of it
    task automatic offer(input action_t act, input logic [31:0] value);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        push_value <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // random word, with the extremes and a few familiar values mixed in
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4:       return 32'd99999;
            default: return $urandom;
        endcase
    endfunction

    function automatic action_t pick_action(int push_w, int pop_w, int read_w);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_w)
            return ACT_PUSH;
        if (roll < push_w + pop_w)
            return ACT_POP;
        if (roll < push_w + pop_w + read_w)
            return ACT_READ;
        return ACT_SWAP;
    endfunction

    // mixed traffic that keeps the stack shallow; idling switches on and off
    // in stretches of 40 requests unless told to stay off
    task automatic run_mixed(input int count, input bit allow_idle);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            offer(pick_action(35, 30, 15), pick_word());
        end
    endtask

    initial
    begin
        action_t act;
        int      goal;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: refusals on an empty stack, extreme words, swap basics
        offer(ACT_READ, 32'h0);
        offer(ACT_POP, 32'hffff_ffff);
        offer(ACT_SWAP, 32'h0);
        offer(ACT_PUSH, 32'h8000_0000);
        offer(ACT_SWAP, 32'h0);
        offer(ACT_READ, 32'h0);
        offer(ACT_PUSH, 32'h7fff_ffff);
        offer(ACT_PUSH, 32'hffff_ffff);
        offer(ACT_PUSH, 32'd99999);
        offer(ACT_PUSH, 32'h0);
        offer(ACT_SWAP, 32'h1234_5678);
        offer(ACT_READ, 32'h0);
        offer(ACT_SWAP, 32'h0);
        offer(ACT_POP, 32'h0);
        offer(ACT_SWAP, 32'h0);
        offer(ACT_READ, 32'h0);
        offer(ACT_POP, 32'h0);
        offer(ACT_POP, 32'h0);
        offer(ACT_POP, 32'h0);
        offer(ACT_POP, 32'h0);
        offer(ACT_READ, 32'h0);

        // shallow random traffic, with the hold-off landing in here
        run_mixed(180, 1'b1);

        // build the stack up deep with random words; reads and swaps sprinkled in
        idle_on = 1'b1;
        goal    = FILL_PUSHES;
        while (goal > 0)
        begin
            if ($urandom_range(0, 7) == 0)
                act = ($urandom_range(0, 1) == 0) ? ACT_READ : ACT_SWAP;
            else
            begin
                act = ACT_PUSH;
                goal--;
            end
            if (goal % 40 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            offer(act, pick_word());
        end

        // deep stack: swap and read at the top, push and pop around it
        offer(ACT_SWAP, 32'h0);
        offer(ACT_READ, 32'h0);
        offer(ACT_PUSH, 32'h8000_0000);
        offer(ACT_POP, 32'h0);
        offer(ACT_PUSH, 32'h7fff_ffff);
        offer(ACT_PUSH, 32'hffff_ffff);

        // drain back past empty, checking every buried word on the way out
        goal = FILL_PUSHES + 40;
        while (goal > 0)
        begin
            if ($urandom_range(0, 7) == 0)
                act = ($urandom_range(0, 1) == 0) ? ACT_READ : ACT_SWAP;
            else
            begin
                act = ACT_POP;
                goal--;
            end
            if (goal % 40 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            offer(act, pick_word());
        end

        run_mixed(80, 1'b1);

        // closing stretch at full rate on both sides
        run_mixed(60, 1'b0);
        idle_on = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d requests and %0d checked responses, %0d of them refused",
                 requests_sent, checked, refused);
        $display("stack reached %0d of %0d entries; receiver held off for %0d cycles once",
                 peak_depth, DEPTH, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("hardware_stack_with_swap_top test passed");
        else
            $display("hardware_stack_with_swap_top test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/hsws_pkg.sv
rtl/core/hsws_ram.sv
rtl/core/hsws_ctrl.sv
rtl/core/hardware_stack_with_swap_top.sv
bench/hsws_checker.sv
bench/hardware_stack_with_swap_top_test.sv
